/* rtl/rc4_keystream_16_lane_core_assert.svh */
// Assertion macros for the checker file of the keystream core.
`ifndef RC4_KEYSTREAM_16_LANE_CORE_ASSERT_SVH
`define RC4_KEYSTREAM_16_LANE_CORE_ASSERT_SVH

// Clocked assertion, off while reset is high.
`define RC4KS_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Clocked assertion that also holds across reset.
`define RC4KS_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/rc4ks_pkg.sv */
// Shared types and constants of the sixteen-lane RC4 keystream core.
`timescale 1ns / 1ps
`default_nettype none

package rc4ks_pkg;

   localparam int LANES     = 16;
   localparam int MAX_LANES = 16;

   localparam int BYTE_W     = 8;
   localparam int LANE_W     = 4;
   localparam int CMD_W      = 2;
   localparam int WORD_W     = 64;
   localparam int REQ_DATA_W = 168;
   localparam int RSP_DATA_W = 128;

   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INDEX = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CRYPT = 2'd2;

   // Lockstep control from the sequencer to every lane.
   typedef struct packed {
      logic              crypt_start;
      logic              step_j;
      logic              step_swap;
      logic              finish;
      logic              wr_en;
      logic              set_idx;
      logic [LANE_W-1:0] lane;
      logic [BYTE_W-1:0] sbox_index;
      logic [BYTE_W-1:0] sbox_value;
      logic [BYTE_W-1:0] index_i;
      logic [BYTE_W-1:0] index_j;
   } ctl_type;

   typedef logic [LANES-1:0][BYTE_W-1:0] lane_bytes_type;

endpackage

`default_nettype wire

/* rtl/rc4_keystream_16_lane_core.sv */
// Crypt path: accepting cycle, READ_J, SWAP, DONE; the response register loads as DONE
// finishes with the output free. Next crypt is taken only then, set by the three dependent
// reads of each lane's single-write-port permutation memory; entry writes wait for IDLE.
// A response stalled at the output holds the lanes in their final step.
// Synchronous active-high reset clears i, j, the sequencer and the output valid;
// permutation memories are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none

module rc4_keystream_16_lane_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // lane[3:0], sbox_index[11:4], sbox_value[19:12], index_i[27:20],
   // index_j[35:28], data_lo[99:36], data_hi[163:100], zero[167:164]
   input  wire logic [rc4ks_pkg::REQ_DATA_W-1:0]     req_tdata,
   // cmd[1:0]
   input  wire logic [rc4ks_pkg::CMD_W-1:0]          req_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // out_lo[63:0], out_hi[127:64]
   output logic      [rc4ks_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ_J,
      ST_SWAP,
      ST_DONE
   } state_type;

   state_type                   state_ff;
   logic                        accept;
   logic                        out_free;
   logic                        finish;
   rc4ks_pkg::ctl_type          ctl;
   rc4ks_pkg::lane_bytes_type   lane_bytes;
   logic [2*rc4ks_pkg::WORD_W-1:0] data_words;

   // entry writes wait out the final step, which owns the memory write port
   assign finish     = (state_ff == ST_DONE) && out_free;
   assign req_tready = (state_ff == ST_IDLE) ||
                       (finish && req_tuser != rc4ks_pkg::CMD_WRITE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && req_tuser == rc4ks_pkg::CMD_CRYPT) begin
                  state_ff <= ST_READ_J;
               end
            end
            ST_READ_J: state_ff <= ST_SWAP;
            ST_SWAP:   state_ff <= ST_DONE;
            ST_DONE: begin
               if (finish) begin
                  state_ff <= (accept && req_tuser == rc4ks_pkg::CMD_CRYPT) ? ST_READ_J
                                                                            : ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      ctl.crypt_start = accept && req_tuser == rc4ks_pkg::CMD_CRYPT;
      ctl.step_j      = (state_ff == ST_READ_J);
      ctl.step_swap   = (state_ff == ST_SWAP);
      ctl.finish      = finish;
      ctl.wr_en       = accept && req_tuser == rc4ks_pkg::CMD_WRITE;
      ctl.set_idx     = accept && req_tuser == rc4ks_pkg::CMD_INDEX;
      ctl.lane        = req_tdata[3:0];
      ctl.sbox_index  = req_tdata[11:4];
      ctl.sbox_value  = req_tdata[19:12];
      ctl.index_i     = req_tdata[27:20];
      ctl.index_j     = req_tdata[35:28];
   end

   assign data_words = req_tdata[163:36];

   for (genvar n = 0; n < rc4ks_pkg::LANES; n++) begin : g_lane
      rc4ks_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .lane_id   (rc4ks_pkg::LANE_W'(n)),
         .ctl       (ctl),
         .data_byte (data_words[n*rc4ks_pkg::BYTE_W +: rc4ks_pkg::BYTE_W]),
         .byte_out  (lane_bytes[n])
      );
   end

   rc4ks_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .finish     (finish),
      .lane_bytes (lane_bytes),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .out_free   (out_free)
   );

endmodule

`default_nettype wire

/* rtl/rc4ks_lane.sv */
// One RC4 output generator: 256-entry permutation memory, i and j, swap and mask.
`timescale 1ns / 1ps
`default_nettype none

module rc4ks_lane (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic [rc4ks_pkg::LANE_W-1:0]   lane_id,
   input  wire rc4ks_pkg::ctl_type             ctl,
   input  wire logic [rc4ks_pkg::BYTE_W-1:0]   data_byte,
   output logic      [rc4ks_pkg::BYTE_W-1:0]   byte_out
);

   logic [rc4ks_pkg::BYTE_W-1:0] mem [256];

   logic [rc4ks_pkg::BYTE_W-1:0] i_ff, j_ff, si_ff, sj_ff, t_ff, data_ff;
   logic [rc4ks_pkg::BYTE_W-1:0] rd_addr_ff, rd_data_ff;
   logic                         wrote_en_ff;
   logic [rc4ks_pkg::BYTE_W-1:0] wrote_addr_ff, wrote_data_ff;

   logic                         lane_sel;
   logic [rc4ks_pkg::BYTE_W-1:0] rd_eff;
   logic                         wr_en_in;
   logic [rc4ks_pkg::BYTE_W-1:0] wr_addr_in, wr_data_in;
   logic                         rd_en_in;
   logic [rc4ks_pkg::BYTE_W-1:0] rd_addr_in;
   logic [rc4ks_pkg::BYTE_W-1:0] key;

   assign lane_sel = (ctl.lane == lane_id);

   // read landing on the edge of a write sees the old entry; patch it here
   assign rd_eff = (wrote_en_ff && wrote_addr_ff == rd_addr_ff) ? wrote_data_ff : rd_data_ff;

   always_comb begin
      priority if (ctl.step_swap) begin
         wr_en_in   = 1'b1;
         wr_addr_in = i_ff;
         wr_data_in = rd_eff;
      end else if (ctl.finish) begin
         wr_en_in   = 1'b1;
         wr_addr_in = j_ff;
         wr_data_in = si_ff;
      end else if (ctl.wr_en && lane_sel) begin
         wr_en_in   = 1'b1;
         wr_addr_in = ctl.sbox_index;
         wr_data_in = ctl.sbox_value;
      end else begin
         wr_en_in   = 1'b0;
         wr_addr_in = i_ff;
         wr_data_in = rd_eff;
      end
   end

   always_comb begin
      rd_en_in = ctl.crypt_start | ctl.step_j | ctl.step_swap;
      priority if (ctl.crypt_start) begin
         rd_addr_in = i_ff + 8'd1;
      end else if (ctl.step_j) begin
         rd_addr_in = j_ff + rd_eff;
      end else begin
         rd_addr_in = si_ff + rd_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en_in) begin
         mem[wr_addr_in] <= wr_data_in;
      end
      if (rd_en_in) begin
         rd_data_ff <= mem[rd_addr_in];
         rd_addr_ff <= rd_addr_in;
      end
      wrote_addr_ff <= wr_addr_in;
      wrote_data_ff <= wr_data_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff        <= '0;
         j_ff        <= '0;
         wrote_en_ff <= 1'b0;
      end else begin
         wrote_en_ff <= wr_en_in;
         priority if (ctl.crypt_start) begin
            i_ff <= i_ff + 8'd1;
         end else if (ctl.set_idx && lane_sel) begin
            i_ff <= ctl.index_i;
         end else begin
            i_ff <= i_ff;
         end
         priority if (ctl.step_j) begin
            j_ff <= j_ff + rd_eff;
         end else if (ctl.set_idx && lane_sel) begin
            j_ff <= ctl.index_j;
         end else begin
            j_ff <= j_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.crypt_start) begin
         data_ff <= data_byte;
      end
      if (ctl.step_j) begin
         si_ff <= rd_eff;
      end
      if (ctl.step_swap) begin
         sj_ff <= rd_eff;
         t_ff  <= si_ff + rd_eff;
      end
   end

   // entry t was read before the swap landed: take swapped values directly
   always_comb begin
      priority if (t_ff == i_ff) begin
         key = sj_ff;
      end else if (t_ff == j_ff) begin
         key = si_ff;
      end else begin
         key = rd_data_ff;
      end
   end

   assign byte_out = data_ff ^ key;

endmodule

`default_nettype wire

/* rtl/rc4ks_merge.sv */
// Gathers the lane bytes into one response word and holds it in the output register.
`timescale 1ns / 1ps
`default_nettype none

module rc4ks_merge (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               finish,
   input  wire rc4ks_pkg::lane_bytes_type          lane_bytes,
   input  wire logic                               rsp_tready,
   output logic                                    rsp_tvalid,
   output logic [rc4ks_pkg::RSP_DATA_W-1:0]        rsp_tdata,
   output logic                                    out_free
);

   logic [rc4ks_pkg::RSP_DATA_W-1:0] packed_in;
   logic                             rsp_valid_ff;
   logic [rc4ks_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   for (genvar n = 0; n < rc4ks_pkg::MAX_LANES; n++) begin : g_slot
      if (n < rc4ks_pkg::LANES) begin : g_live
         assign packed_in[n*rc4ks_pkg::BYTE_W +: rc4ks_pkg::BYTE_W] = lane_bytes[n];
      end else begin : g_absent
         assign packed_in[n*rc4ks_pkg::BYTE_W +: rc4ks_pkg::BYTE_W] = '0;
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= finish;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free && finish) begin
         rsp_data_ff <= packed_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/rc4ks_checker.sv */
// Port-level checker for the keystream core and its bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "rc4_keystream_16_lane_core_assert.svh"

module rc4ks_checker (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   input  wire logic                                 req_tready,
   input  wire logic [rc4ks_pkg::CMD_W-1:0]          req_tuser,
   input  wire logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic [rc4ks_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   logic crypt_acc;
   logic rsp_stall;

   assign crypt_acc = req_tvalid && req_tready && req_tuser == rc4ks_pkg::CMD_CRYPT;
   assign rsp_stall = rsp_tvalid && !rsp_tready;

   `RC4KS_ASSERT_ALWAYS(a_reset_clears_rsp, reset |=> !rsp_tvalid, "response valid after reset")

   `RC4KS_ASSERT(a_rsp_holds, rsp_stall |=> rsp_tvalid && $stable(rsp_tdata), "stalled response")

   `RC4KS_ASSERT(a_crypt_busy, crypt_acc |=> !req_tready ##1 !req_tready, "request in crypt")

   // response register loads as the sequencer leaves DONE; rsp_tvalid comes from that register
   `RC4KS_ASSERT(a_crypt_latency, crypt_acc && !rsp_tvalid |-> ##4 rsp_tvalid, "no response")

endmodule

bind rc4_keystream_16_lane_core rc4ks_checker u_checker (.*);

`default_nettype wire
